/* src/threshold_vote_distance_average_macros.svh */
// Assertion macros shared by the threshold vote distance averager RTL.
`ifndef THRESHOLD_VOTE_DISTANCE_AVERAGE_MACROS_SVH
`define THRESHOLD_VOTE_DISTANCE_AVERAGE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every rising edge outside reset.
`define TVDA_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked at every rising edge outside reset.
`define TVDA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`else

`define TVDA_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define TVDA_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* src/tvda_pkg.sv */
// Shared types and constants of the threshold vote distance averager.
`default_nettype none

package tvda_pkg;

	// Width of one distance value and of the threshold register.
	localparam int DATA_W = 15;
	// Stream data width: one distance value padded to whole bytes.
	localparam int TDATA_W = 16;
	// Threshold after reset (indoor setting); software writes 300 for outdoor use.
	localparam logic [DATA_W-1:0] THRESHOLD_RESET = 15'd150;

	// Status of the shared divider as seen by the sequencer.
	typedef struct packed {
		logic busy;
		logic done;
	} tvda_div_stat_t;

endpackage

`default_nettype wire

/* src/tvda_div.sv */
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none

module tvda_div #(
	parameter int SUM_W = 17,
	parameter int CNT_W = 2
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [SUM_W-1:0]             dividend,
	input  logic [CNT_W-1:0]             divisor,
	output logic [tvda_pkg::DATA_W-1:0]  quotient,
	output tvda_pkg::tvda_div_stat_t     stat
);
	import tvda_pkg::*;

	localparam int STEP_W = $clog2(SUM_W);

	logic               busy_q;
	logic               done_q;
	logic [STEP_W-1:0]  step_q;
	logic [SUM_W-1:0]   dvd_q;
	logic [SUM_W-1:0]   quo_q;
	logic [CNT_W-1:0]   dvs_q;
	logic [CNT_W-1:0]   rem_q;

	logic [CNT_W:0]     rem_sh;
	logic [CNT_W:0]     rem_diff;
	logic               fits;
	logic [CNT_W-1:0]   rem_nx;

	// The remainder stays below the divisor, so one extra bit holds the shifted value.
	assign rem_sh   = {rem_q, dvd_q[SUM_W-1]};
	assign fits     = rem_sh >= {1'b0, dvs_q};
	assign rem_diff = rem_sh - {1'b0, dvs_q};
	assign rem_nx   = fits ? rem_diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
			dvd_q  <= '0;
			quo_q  <= '0;
			dvs_q  <= '0;
			rem_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
				dvd_q  <= dividend;
				dvs_q  <= divisor;
				rem_q  <= '0;
			end else if (busy_q) begin
				dvd_q  <= {dvd_q[SUM_W-2:0], 1'b0};
				quo_q  <= {quo_q[SUM_W-2:0], fits};
				rem_q  <= rem_nx;
				step_q <= step_q + STEP_W'(1);
				if (step_q == STEP_W'(SUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// The average never exceeds the largest reading, so the low bits hold it whole.
	assign quotient = quo_q[DATA_W-1:0];
	assign stat     = '{busy: busy_q, done: done_q};

endmodule

`default_nettype wire

/* src/threshold_vote_distance_average.sv */
// Top level of the threshold vote distance averager: group sequencer and output register.
// A reading that does not close a group is taken without a stall; the next request is ready at once.
// A reading that closes a group runs the shared bit-serial divider over all SUM_W dividend bits
// (15 + clog2(GROUP_SIZE), 17 by default) unless its class is empty; the result shows on m_tvalid
// once ST_HOLD loads the output register, and the next request is taken in the cycle after that load.
// arst_n clears the group counters, the sums and both handshakes; the threshold resets to 150.
`default_nettype none
`include "threshold_vote_distance_average_macros.svh"

module threshold_vote_distance_average #(
	parameter int GROUP_SIZE   = 3,
	parameter int MIN_POSITIVE = 2
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          threshold_we,
	input  logic [tvda_pkg::DATA_W-1:0]   threshold_wdata,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [tvda_pkg::TDATA_W-1:0]  s_tdata,  // [14:0] reading, [15] zero pad
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [tvda_pkg::TDATA_W-1:0]  m_tdata,  // [14:0] avg_distance, [15] zero pad
	output logic                          m_tuser   // [0] detected
);
	import tvda_pkg::*;

	localparam int SUM_W = DATA_W + $clog2(GROUP_SIZE);
	localparam int CNT_W = $clog2(GROUP_SIZE + 1);

	typedef enum logic [1:0] {
		ST_ACC,
		ST_DIV,
		ST_HOLD
	} state_t;

	state_t              state_q;
	logic [DATA_W-1:0]   threshold_q;
	logic [CNT_W-1:0]    idx_q;
	logic [CNT_W-1:0]    pos_cnt_q;
	logic [SUM_W-1:0]    pos_sum_q;
	logic [SUM_W-1:0]    neg_sum_q;
	logic                hit_q;
	logic [DATA_W-1:0]   res_avg_q;
	logic                m_valid_q;
	logic [DATA_W-1:0]   m_avg_q;
	logic                m_hit_q;

	logic [DATA_W-1:0]   reading;
	logic                is_pos;
	logic                accept;
	logic                last;
	logic [CNT_W-1:0]    pos_cnt_nx;
	logic [CNT_W-1:0]    neg_cnt_nx;
	logic [SUM_W-1:0]    pos_sum_nx;
	logic [SUM_W-1:0]    neg_sum_nx;
	logic                hit_nx;
	logic [SUM_W-1:0]    div_dvd;
	logic [CNT_W-1:0]    div_dvs;
	logic                div_start;
	logic [DATA_W-1:0]   div_quo;
	tvda_div_stat_t      div_stat;

	assign reading    = s_tdata[DATA_W-1:0];
	assign is_pos     = reading <= threshold_q;
	assign accept     = s_tvalid && s_tready;
	assign last       = idx_q == CNT_W'(GROUP_SIZE - 1);
	assign pos_cnt_nx = pos_cnt_q + CNT_W'(is_pos);
	assign neg_cnt_nx = CNT_W'(GROUP_SIZE) - pos_cnt_nx;
	assign pos_sum_nx = pos_sum_q + (is_pos ? SUM_W'(reading) : SUM_W'(0));
	assign neg_sum_nx = neg_sum_q + (is_pos ? SUM_W'(0) : SUM_W'(reading));
	assign hit_nx     = {{(32 - CNT_W){1'b0}}, pos_cnt_nx} >= 32'(MIN_POSITIVE);
	assign div_dvd    = hit_nx ? pos_sum_nx : neg_sum_nx;
	assign div_dvs    = hit_nx ? pos_cnt_nx : neg_cnt_nx;
	// An empty class averages to zero and skips the divider.
	assign div_start  = accept && last && (div_dvs != '0);

	tvda_div #(
		.SUM_W (SUM_W),
		.CNT_W (CNT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.quotient (div_quo),
		.stat     (div_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_ACC;
			threshold_q <= THRESHOLD_RESET;
			idx_q       <= '0;
			pos_cnt_q   <= '0;
			pos_sum_q   <= '0;
			neg_sum_q   <= '0;
			hit_q       <= 1'b0;
			res_avg_q   <= '0;
			m_valid_q   <= 1'b0;
			m_avg_q     <= '0;
			m_hit_q     <= 1'b0;
		end else begin
			if (threshold_we) begin
				threshold_q <= threshold_wdata;
			end
			// In ST_HOLD the load below also covers a result leaving in this cycle.
			if (m_valid_q && m_tready && state_q != ST_HOLD) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_ACC: begin
					if (accept) begin
						if (last) begin
							idx_q     <= '0;
							pos_cnt_q <= '0;
							pos_sum_q <= '0;
							neg_sum_q <= '0;
							hit_q     <= hit_nx;
							if (div_dvs == '0) begin
								res_avg_q <= '0;
								state_q   <= ST_HOLD;
							end else begin
								state_q <= ST_DIV;
							end
						end else begin
							idx_q     <= idx_q + CNT_W'(1);
							pos_cnt_q <= pos_cnt_nx;
							pos_sum_q <= pos_sum_nx;
							neg_sum_q <= neg_sum_nx;
						end
					end
				end
				ST_DIV: begin
					if (div_stat.done) begin
						res_avg_q <= div_quo;
						state_q   <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					// Load the result once the previous one has left the output register.
					if (!m_valid_q || m_tready) begin
						m_valid_q <= 1'b1;
						m_avg_q   <= res_avg_q;
						m_hit_q   <= hit_q;
						state_q   <= ST_ACC;
					end
				end
				default: begin
					state_q <= ST_ACC;
				end
			endcase
		end
	end

	assign s_tready = state_q == ST_ACC;
	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{(TDATA_W - DATA_W){1'b0}}, m_avg_q};
	assign m_tuser  = m_hit_q;

	`TVDA_ASSERT_IMPLIES(a_no_req_while_div, clk, arst_n, div_stat.busy, !s_tready)
	`TVDA_ASSERT_IMPLIES(a_done_only_in_div, clk, arst_n, div_stat.done, state_q == ST_DIV)
	`TVDA_ASSERT_NEXT(a_hold_loads_output, clk, arst_n, state_q == ST_HOLD && (!m_valid_q || m_tready), m_valid_q && state_q == ST_ACC)
	`TVDA_ASSERT_NEXT(a_group_end_starts, clk, arst_n, accept && last && div_dvs != '0, div_stat.busy && state_q == ST_DIV)

endmodule

`default_nettype wire

/* tb/threshold_vote_distance_average_tb.sv */
// Self-checking testbench for the threshold vote distance averager stream block.
`default_nettype none

module threshold_vote_distance_average_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int GROUP_SIZE = 3;
	localparam int MIN_POSITIVE = 2;
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned RANDOM_READINGS = 1500;
	localparam int MAX_REPORTS = 10;
	localparam int DRAIN_CYCLES = 30;
	localparam int LONG_HOLD = 400;

	typedef logic [tvda_pkg::DATA_W-1:0] dist_t;

	typedef struct packed {
		dist_t avg;
		logic detected;
	} verdict_t;

	// Tracks the group vote and keeps the verdicts still owed by the block.
	class vote_scoreboard;
		dist_t threshold;
		int unsigned fill;
		int unsigned hits;
		int unsigned hit_sum;
		int unsigned miss_sum;
		int unsigned mismatches;
		verdict_t pending[$];

		function new();
			threshold = tvda_pkg::THRESHOLD_RESET;
			fill = 0;
			hits = 0;
			hit_sum = 0;
			miss_sum = 0;
			mismatches = 0;
		endfunction

		function dist_t mean(int unsigned sum, int unsigned count);
			if (count == 0)
				return '0;
			return dist_t'(sum / count);
		endfunction

		function void note_reading(dist_t r);
			verdict_t v;
			if (r <= threshold) begin
				hits++;
				hit_sum += r;
			end else begin
				miss_sum += r;
			end
			fill++;
			if (fill < GROUP_SIZE)
				return;
			v.detected = (hits >= MIN_POSITIVE);
			v.avg = v.detected ? mean(hit_sum, hits) : mean(miss_sum, fill - hits);
			pending.push_back(v);
			fill = 0;
			hits = 0;
			hit_sum = 0;
			miss_sum = 0;
		endfunction

		function void flag(string what);
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("%0t: %s", $realtime, what);
		endfunction

		function void check_result(dist_t avg, logic detected);
			verdict_t want;
			if (pending.size() == 0) begin
				flag($sformatf("result avg=%0d detected=%0d with no verdict pending",
					avg, detected));
				return;
			end
			want = pending.pop_front();
			if (avg !== want.avg)
				flag($sformatf("avg_distance expected %0d, got %0d", want.avg, avg));
			if (detected !== want.detected)
				flag($sformatf("detected expected %0d, got %0d", want.detected, detected));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic threshold_we = 1'b0;
	dist_t threshold_wdata = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [tvda_pkg::TDATA_W-1:0] s_tdata = '0;  // [14:0] reading, [15] zero pad
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [tvda_pkg::TDATA_W-1:0] m_tdata;  // [14:0] avg_distance, [15] zero pad
	logic m_tuser;  // [0] detected

	vote_scoreboard sb;
	bit src_steady = 1'b0;
	int unsigned cycles = 0;

	threshold_vote_distance_average #(
		.GROUP_SIZE(GROUP_SIZE),
		.MIN_POSITIVE(MIN_POSITIVE)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.threshold_we(threshold_we),
		.threshold_wdata(threshold_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Called at a falling edge; returns at the falling edge after the request is taken.
	task automatic send_reading(input dist_t r);
		int gap;
		gap = src_steady ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {1'b0, r};
		do @(posedge clk); while (!s_tready);
		sb.note_reading(r);
		@(negedge clk);
	endtask

	// The block must be idle: all verdicts in, plus time for a division in flight.
	task automatic load_threshold(input dist_t t);
		s_tvalid <= 1'b0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		threshold_we <= 1'b1;
		threshold_wdata <= t;
		sb.threshold = t;
		@(negedge clk);
		threshold_we <= 1'b0;
	endtask

	function automatic dist_t pick_reading(dist_t thr);
		int v;
		case ($urandom_range(0, 9))
			0: v = 0;
			1: v = 32767;
			2, 3, 4: v = int'(thr) + int'($urandom_range(0, 8)) - 4;
			5, 6: v = int'($urandom_range(0, int'(thr)));
			7: v = int'($urandom_range(int'(thr), 32767));
			default: v = int'($urandom_range(0, 32767));
		endcase
		if (v < 0)
			v = 0;
		if (v > 32767)
			v = 32767;
		return dist_t'(v);
	endfunction

	initial begin : sink
		int gap;
		int unsigned taken;
		bit steady;
		bit held;
		taken = 0;
		steady = 1'b0;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			if (taken % 32 == 0)
				steady = ($urandom_range(0, 3) == 0);
			gap = steady ? 0 : $urandom_range(0, 6);
			// One long hold-off lets the output back up into the input side.
			if (!held && taken == 40) begin
				gap = LONG_HOLD;
				held = 1'b1;
			end
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			sb.check_result(m_tdata[tvda_pkg::DATA_W-1:0], m_tuser);
			taken++;
			@(negedge clk);
		end
	end

	initial begin : stimulus
		int unsigned opening[14];
		int unsigned issued;
		int unsigned quota;
		dist_t thr;
		opening = '{150, 151, 0, 32767, 32767, 32767, 0, 0, 0,
			151, 150, 32767, 300, 200};
		sb = new();
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		// Reset threshold: votes both ways, a tie-free single positive, and a group
		// left open across the next threshold change.
		foreach (opening[i])
			send_reading(dist_t'(opening[i]));
		load_threshold(15'd300);
		send_reading(15'd250);
		send_reading(15'd300);
		send_reading(15'd301);
		send_reading(15'd0);
		load_threshold(15'd0);
		send_reading(15'd0);
		send_reading(15'd1);
		send_reading(15'd0);
		load_threshold(15'd32767);
		send_reading(15'd32767);
		send_reading(15'd32767);
		send_reading(15'd1);

		issued = 0;
		while (issued < RANDOM_READINGS) begin
			case ($urandom_range(0, 5))
				0: thr = 15'd0;
				1: thr = 15'd150;
				2: thr = 15'd300;
				3: thr = 15'd32767;
				4: thr = dist_t'($urandom_range(0, 1023));
				default: thr = dist_t'($urandom);
			endcase
			load_threshold(thr);
			src_steady = ($urandom_range(0, 3) == 0);
			quota = $urandom_range(60, 240);
			repeat (quota)
				send_reading(pick_reading(thr));
			issued += quota;
		end

		s_tvalid <= 1'b0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

`default_nettype wire
